// ===== rtl/tbpr_pkg.sv =====
// ----------------------------------------------------------------------------
// tbpr_pkg: shared definitions for the tile background pixel renderer
// Store geometry, register indexes, control bit positions, shade mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package tbpr_pkg;

   // video store geometry (offsets from the video base)
   localparam int STORE_BYTES = 8192;
   localparam int ADDR_W      = 13;
   localparam int BANK_DEPTH  = STORE_BYTES / 2;
   localparam int BANK_IDX_W  = ADDR_W - 1;
   localparam int DATA_W      = 8;

   // screen geometry
   localparam int         LINE_WIDTH = 160;
   localparam logic [7:0] LAST_LINE  = 8'd143;

   // map area: offset 0x1800 or 0x1C00, top bits 2'b11 then the map select
   localparam logic [1:0] MAP_AREA_TOP = 2'b11;

   // signed tile data base 0x8800 as an offset, and the tile number bias
   localparam logic [ADDR_W-1:0] DATA_SIGNED_OFF = 13'h0800;
   localparam logic [7:0]        TILE_BIAS       = 8'h80;

   // window X position is the raw register minus seven
   localparam logic [7:0] WINDOW_X_BIAS = 8'd7;

   // item opcodes
   typedef enum logic [0:0] {
      OP_WRITE  = 1'b0,
      OP_RENDER = 1'b1
   } opcode_type;

   // control register indexes
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCROLL_Y     = 3'd0,
      CSR_SCROLL_X     = 3'd1,
      CSR_WINDOW_Y     = 3'd2,
      CSR_WINDOW_X_RAW = 3'd3,
      CSR_LCD_CONTROL  = 3'd4,
      CSR_BG_PALETTE   = 3'd5
   } csr_index_type;

   // lcd_control bit positions
   localparam int LCDC_BG_ENABLE  = 0;
   localparam int LCDC_BG_MAP     = 3;
   localparam int LCDC_TILE_DATA  = 4;
   localparam int LCDC_WIN_ENABLE = 5;
   localparam int LCDC_WIN_MAP    = 6;

   // shade 0..3 to grey level
   function automatic logic [7:0] shade_to_grey(input logic [1:0] shade);
      logic [7:0] grey;
      case (shade)
         2'd0:    grey = 8'hFF;
         2'd1:    grey = 8'hCC;
         2'd2:    grey = 8'h77;
         default: grey = 8'h00;
      endcase
      return grey;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tbpr_ram.sv =====
// ----------------------------------------------------------------------------
// tbpr_ram: generic simple dual-port RAM
// One write port, one read port with enable; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns old data on a same-cycle write to the same entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tile_background_pixel_renderer.sv =====
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer: background/window pixel renderer
// Video store split into even/odd byte banks; map read, then tile-row read.
// ----------------------------------------------------------------------------
// Pipeline: map byte into stage 2, both bit-plane bytes into stage 3, then the
//   grey level into the result register. A beat stalls while stage 2 owns the
//   bank read ports (map byte read, then both bit-plane bytes in one read of
//   the two banks) or the pipe is held; write beats go one per cycle otherwise.
// Reset: clears pipeline valids, the result valid and all six control
//   registers; the video store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_background_pixel_renderer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // item channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_opcode,
   input  wire logic [tbpr_pkg::ADDR_W-1:0]      req_store_address,
   input  wire logic [7:0]                       req_write_byte,
   input  wire logic [7:0]                       req_current_line,
   input  wire logic [7:0]                       req_column,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_out_column,
   output logic [7:0]                            rsp_out_line,
   output logic [7:0]                            rsp_grey_level,
   // control register write channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tbpr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [7:0]                       csr_data
);

   localparam int IDX_W = tbpr_pkg::BANK_IDX_W;

   // control registers
   logic [7:0] scroll_y_ff, scroll_x_ff, window_y_ff, window_x_raw_ff;
   logic [7:0] lcd_control_ff, bg_palette_ff;

   // stage 2: map byte returning
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_map_bank_ff;
   logic [2:0]       s2_ypos_lo_ff;
   logic [2:0]       s2_xpos_lo_ff;
   logic             s2_unsigned_ff;
   logic [7:0]       s2_col_ff, s2_line_ff;

   // stage 3: bit-plane bytes returning
   logic             s3_valid_ff, s3_valid_in;
   logic [2:0]       s3_xpos_lo_ff;
   logic [7:0]       s3_col_ff, s3_line_ff;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_col_ff, rsp_line_ff, rsp_grey_ff;

   // bank ports
   logic             bank0_we, bank1_we, bank0_re, bank1_re;
   logic [IDX_W-1:0] bank0_raddr, bank1_raddr, wr_idx;
   logic [7:0]       bank0_rdata, bank1_rdata;

   logic             hold, req_accept, is_render, render_ok, map_rd, tile_rd;
   logic             in_window;
   logic [7:0]       wx, ypos, xpos;
   logic [tbpr_pkg::ADDR_W-1:0] map_off, tile_base;
   logic [IDX_W-1:0] map_idx, tile_idx;
   logic [7:0]       tile_num, bias_num;
   logic [2:0]       pix_sel;
   logic [1:0]       cnum, shade;

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   // a finished pixel in stage 3 with a full, stalled result register
   // freezes the pipe; stage 2 owns both banks' read ports, so it stalls new beats
   assign hold       = s3_valid_ff & rsp_valid_ff & rsp_stall;
   assign req_stall  = s2_valid_ff | hold;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------------
   // control register writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_y_ff     <= 8'd0;
         scroll_x_ff     <= 8'd0;
         window_y_ff     <= 8'd0;
         window_x_raw_ff <= 8'd0;
         lcd_control_ff  <= 8'd0;
         bg_palette_ff   <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tbpr_pkg::CSR_SCROLL_Y:     scroll_y_ff     <= csr_data;
            tbpr_pkg::CSR_SCROLL_X:     scroll_x_ff     <= csr_data;
            tbpr_pkg::CSR_WINDOW_Y:     window_y_ff     <= csr_data;
            tbpr_pkg::CSR_WINDOW_X_RAW: window_x_raw_ff <= csr_data;
            tbpr_pkg::CSR_LCD_CONTROL:  lcd_control_ff  <= csr_data;
            tbpr_pkg::CSR_BG_PALETTE:   bg_palette_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: coordinates and map address from the accepted beat
   // ---------------------------------------------------------------------
   assign is_render = (req_opcode == tbpr_pkg::OP_RENDER);
   assign render_ok = is_render
                    & lcd_control_ff[tbpr_pkg::LCDC_BG_ENABLE]
                    & (req_current_line <= tbpr_pkg::LAST_LINE)
                    & (req_column < 8'(tbpr_pkg::LINE_WIDTH));
   assign map_rd    = req_accept & render_ok;

   always_comb begin
      in_window = lcd_control_ff[tbpr_pkg::LCDC_WIN_ENABLE]
                & (window_y_ff <= req_current_line);
      wx        = window_x_raw_ff - tbpr_pkg::WINDOW_X_BIAS;
      ypos      = in_window ? (req_current_line - window_y_ff)
                            : (req_current_line + scroll_y_ff);
      // left of the window X the scrolled X is kept, also on window lines
      xpos      = (in_window && (req_column >= wx)) ? (req_column - wx)
                                                    : (req_column + scroll_x_ff);
      map_off   = {tbpr_pkg::MAP_AREA_TOP,
                   in_window ? lcd_control_ff[tbpr_pkg::LCDC_WIN_MAP]
                             : lcd_control_ff[tbpr_pkg::LCDC_BG_MAP],
                   ypos[7:3], xpos[7:3]};
      map_idx   = map_off[tbpr_pkg::ADDR_W-1:1];
   end

   // ---------------------------------------------------------------------
   // stage 2: tile number to bit-plane address
   // ---------------------------------------------------------------------
   assign tile_rd = s2_valid_ff;

   always_comb begin
      tile_num = s2_map_bank_ff ? bank1_rdata : bank0_rdata;
      bias_num = tile_num ^ tbpr_pkg::TILE_BIAS;
      if (s2_unsigned_ff) begin
         tile_base = {1'b0, tile_num, 4'b0000};
      end else begin
         tile_base = tbpr_pkg::DATA_SIGNED_OFF + {1'b0, bias_num, 4'b0000};
      end
      // row offset is even: low plane in the even bank, high in the odd
      tile_idx = {tile_base[tbpr_pkg::ADDR_W-1:4], s2_ypos_lo_ff};
   end

   // ---------------------------------------------------------------------
   // bank access: a write sees no conflict with reads; a read in the same
   // cycle as a later write to that byte returns the old value, in order
   // ---------------------------------------------------------------------
   assign wr_idx      = req_store_address[tbpr_pkg::ADDR_W-1:1];
   assign bank0_we    = req_accept & ~is_render & ~req_store_address[0];
   assign bank1_we    = req_accept & ~is_render &  req_store_address[0];
   assign bank0_re    = tile_rd | (map_rd & ~map_off[0]);
   assign bank1_re    = tile_rd | (map_rd &  map_off[0]);
   assign bank0_raddr = tile_rd ? tile_idx : map_idx;
   assign bank1_raddr = tile_rd ? tile_idx : map_idx;

   tbpr_ram #(
      .WIDTH (tbpr_pkg::DATA_W),
      .DEPTH (tbpr_pkg::BANK_DEPTH)
   ) u_bank_even (
      .clock   (clock),
      .wr_en   (bank0_we),
      .wr_addr (wr_idx),
      .wr_data (req_write_byte),
      .rd_en   (bank0_re),
      .rd_addr (bank0_raddr),
      .rd_data (bank0_rdata)
   );

   tbpr_ram #(
      .WIDTH (tbpr_pkg::DATA_W),
      .DEPTH (tbpr_pkg::BANK_DEPTH)
   ) u_bank_odd (
      .clock   (clock),
      .wr_en   (bank1_we),
      .wr_addr (wr_idx),
      .wr_data (req_write_byte),
      .rd_en   (bank1_re),
      .rd_addr (bank1_raddr),
      .rd_data (bank1_rdata)
   );

   // ---------------------------------------------------------------------
   // stage 3: colour number, palette, grey level
   // ---------------------------------------------------------------------
   always_comb begin
      pix_sel = ~s3_xpos_lo_ff;
      cnum    = {bank1_rdata[pix_sel], bank0_rdata[pix_sel]};
      shade   = bg_palette_ff[{cnum, 1'b0} +: 2];
   end

   // ---------------------------------------------------------------------
   // pipeline valids and result register
   // ---------------------------------------------------------------------
   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s3_valid_in  = s3_valid_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (!hold) begin
         s2_valid_in = map_rd;
         s3_valid_in = s2_valid_ff;
         if (s3_valid_ff) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (map_rd) begin
         s2_map_bank_ff <= map_off[0];
         s2_ypos_lo_ff  <= ypos[2:0];
         s2_xpos_lo_ff  <= xpos[2:0];
         s2_unsigned_ff <= lcd_control_ff[tbpr_pkg::LCDC_TILE_DATA];
         s2_col_ff      <= req_column;
         s2_line_ff     <= req_current_line;
      end
      if (tile_rd) begin
         s3_xpos_lo_ff <= s2_xpos_lo_ff;
         s3_col_ff     <= s2_col_ff;
         s3_line_ff    <= s2_line_ff;
      end
      if (s3_valid_ff && !hold) begin
         rsp_col_ff  <= s3_col_ff;
         rsp_line_ff <= s3_line_ff;
         rsp_grey_ff <= tbpr_pkg::shade_to_grey(shade);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_column = rsp_col_ff;
   assign rsp_out_line   = rsp_line_ff;
   assign rsp_grey_level = rsp_grey_ff;

endmodule

`default_nettype wire

// ===== tb/background_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// background_pixel_checker: pixel prediction and comparison
// Watches the item, result and register channels of the renderer. Keeps a
// copy of the video store and the six control registers, works out the grey
// level of every accepted render beat, and checks each result beat against
// the oldest predicted pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module background_pixel_checker
   import tbpr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic                 req_opcode,
   input  wire logic [ADDR_W-1:0]    req_store_address,
   input  wire logic [7:0]           req_write_byte,
   input  wire logic [7:0]           req_current_line,
   input  wire logic [7:0]           req_column,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [7:0]           rsp_out_column,
   input  wire logic [7:0]           rsp_out_line,
   input  wire logic [7:0]           rsp_grey_level,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]           csr_data,
   output int                        mismatch_count,
   output int                        pending_pixels
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] column;
      logic [7:0] line;
      logic [7:0] grey;
   } pixel_type;

   // copy of the video store and the control registers
   logic [7:0] vram_copy [STORE_BYTES];
   logic [7:0] scroll_y_q, scroll_x_q, win_y_q, win_x_raw_q, lcdc_q, palette_q;

   pixel_type expected_pixels [$];

   // grey level of a render beat; returns 0 when no pixel comes out
   function automatic bit predict_pixel(input logic [7:0] line, input logic [7:0] col,
                                        output pixel_type px);
      logic              in_win, map_hi;
      logic [7:0]        ypos, xpos, win_x, tile, plane_lo, plane_hi;
      logic [ADDR_W-1:0] map_off, row_off;
      logic [2:0]        bit_sel;
      logic [1:0]        color, shade;
      px = '0;
      if (!lcdc_q[LCDC_BG_ENABLE] || line > LAST_LINE || col >= LINE_WIDTH)
         return 1'b0;

      // window takes over once the line reaches window_y
      in_win = lcdc_q[LCDC_WIN_ENABLE] && (win_y_q <= line);
      map_hi = in_win ? lcdc_q[LCDC_WIN_MAP] : lcdc_q[LCDC_BG_MAP];
      ypos   = in_win ? line - win_y_q : line + scroll_y_q;

      // left of the window edge the scrolled X is used, even on the window map
      win_x = win_x_raw_q - WINDOW_X_BIAS;
      xpos  = (in_win && col >= win_x) ? col - win_x : col + scroll_x_q;

      map_off = {MAP_AREA_TOP, map_hi, ypos[7:3], xpos[7:3]};
      tile    = vram_copy[map_off];

      // 16 bytes per tile, 2 bytes per tile row
      if (lcdc_q[LCDC_TILE_DATA]) begin
         row_off = {1'b0, tile, ypos[2:0], 1'b0};
      end else begin
         row_off = DATA_SIGNED_OFF + {1'b0, tile ^ TILE_BIAS, ypos[2:0], 1'b0};
      end
      plane_lo = vram_copy[row_off];
      plane_hi = vram_copy[row_off + 1'b1];

      // leftmost pixel sits in bit 7
      bit_sel = 3'd7 - xpos[2:0];
      color   = {plane_hi[bit_sel], plane_lo[bit_sel]};
      shade   = palette_q[2 * color +: 2];

      px.column = col;
      px.line   = line;
      case (shade)
         2'd0:    px.grey = 8'hFF;
         2'd1:    px.grey = 8'hCC;
         2'd2:    px.grey = 8'h77;
         default: px.grey = 8'h00;
      endcase
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      pixel_type px, want;
      if (reset) begin
         scroll_y_q  = '0;
         scroll_x_q  = '0;
         win_y_q     = '0;
         win_x_raw_q = '0;
         lcdc_q      = '0;
         palette_q   = '0;
         expected_pixels.delete();
         mismatch_count = 0;
         pending_pixels <= 0;
      end else begin
         // result beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%t unexpected pixel: column %0d line %0d grey %02h",
                           $realtime, rsp_out_column, rsp_out_line, rsp_grey_level);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_out_column !== want.column || rsp_out_line !== want.line ||
                   rsp_grey_level !== want.grey) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"%t pixel mismatch: expected column %0d line %0d grey %02h,",
                               " got column %0d line %0d grey %02h"},
                              $realtime, want.column, want.line, want.grey,
                              rsp_out_column, rsp_out_line, rsp_grey_level);
               end
            end
         end

         // register writes; spare indexes are ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCROLL_Y:     scroll_y_q  = csr_data;
               CSR_SCROLL_X:     scroll_x_q  = csr_data;
               CSR_WINDOW_Y:     win_y_q     = csr_data;
               CSR_WINDOW_X_RAW: win_x_raw_q = csr_data;
               CSR_LCD_CONTROL:  lcdc_q      = csr_data;
               CSR_BG_PALETTE:   palette_q   = csr_data;
               default: ;
            endcase
         end

         // item beat: store a byte or predict a pixel
         if (req_valid && !req_stall) begin
            if (req_opcode == OP_WRITE) begin
               vram_copy[req_store_address] = req_write_byte;
            end else if (predict_pixel(req_current_line, req_column, px)) begin
               expected_pixels.push_back(px);
            end
         end

         pending_pixels <= expected_pixels.size();
      end
   end

endmodule

`default_nettype wire

// ===== tb/tile_background_pixel_renderer_test.sv =====
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer_test: renderer testbench top
// Fills the map entries and tile rows that renders can reach, then runs
// directed render beats over the screen edges, disabled background, window
// edge and store hazards, followed by random phases of writes and renders
// under changing register settings, with random gaps and stalls and one
// long result hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_background_pixel_renderer_test;

   import tbpr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // lcd_control bits
   localparam logic [7:0] BG_ON          = 8'(1 << LCDC_BG_ENABLE);
   localparam logic [7:0] BG_MAP_HI      = 8'(1 << LCDC_BG_MAP);
   localparam logic [7:0] TILES_UNSIGNED = 8'(1 << LCDC_TILE_DATA);
   localparam logic [7:0] WIN_ON         = 8'(1 << LCDC_WIN_ENABLE);
   localparam logic [7:0] WIN_MAP_HI     = 8'(1 << LCDC_WIN_MAP);
   localparam logic [7:0] MAP_SELECTS    = BG_MAP_HI | WIN_MAP_HI;

   // register indexes past the last register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 70;
   localparam int PRESSURE_ITEMS = 50;
   localparam int HOLDOFF_CYCLES = 300;

   // random phases use the low map and scrolls of at most 7, so renders reach
   // map rows 0..18 and map columns 0..20 only
   localparam logic [ADDR_W-1:0] MAP_LOW_OFF = 13'h1800;
   localparam int                MAP_STRIDE  = 32;
   localparam int                MAP_ROWS    = 19;
   localparam int                MAP_COLS    = 21;
   localparam int                SCROLL_MAX  = 7;

   // tiles 0x80..0x87 sit at offset 0x0800 in both tile data modes
   localparam logic [7:0]        FIRST_TILE      = 8'h80;
   localparam int                TILE_COUNT      = 8;
   localparam logic [ADDR_W-1:0] TILE_AREA_OFF   = 13'h0800;
   localparam int                TILE_AREA_BYTES = TILE_COUNT * 16;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = OP_WRITE;
   logic [ADDR_W-1:0]    req_store_address = '0;
   logic [7:0]           req_write_byte = '0;
   logic [7:0]           req_current_line = '0;
   logic [7:0]           req_column = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_out_column;
   logic [7:0]           rsp_out_line;
   logic [7:0]           rsp_grey_level;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_data = '0;

   int mismatch_count;
   int pending_pixels;

   // idle_off is gap control shared by both sides; holdoff_request feeds the result side
   bit idle_off = 1'b0;
   int holdoff_request = 0;

   always #4 clock = ~clock;

   tile_background_pixel_renderer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_store_address (req_store_address),
      .req_write_byte    (req_write_byte),
      .req_current_line  (req_current_line),
      .req_column        (req_column),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_column    (rsp_out_column),
      .rsp_out_line      (rsp_out_line),
      .rsp_grey_level    (rsp_grey_level),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   background_pixel_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_store_address (req_store_address),
      .req_write_byte    (req_write_byte),
      .req_current_line  (req_current_line),
      .req_column        (req_column),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_column    (rsp_out_column),
      .rsp_out_line      (rsp_out_line),
      .rsp_grey_level    (rsp_grey_level),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .pending_pixels    (pending_pixels)
   );

   // one item beat after a random gap; valid stays up for a back-to-back beat
   task automatic send_beat(input opcode_type op, input logic [ADDR_W-1:0] addr,
                            input logic [7:0] data, input logic [7:0] line,
                            input logic [7:0] col);
      int gap;
      gap = idle_off ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_store_address <= addr;
      req_write_byte    <= data;
      req_current_line  <= line;
      req_column        <= col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic store_byte(input logic [ADDR_W-1:0] addr, input logic [7:0] data);
      send_beat(OP_WRITE, addr, data, 8'($urandom), 8'($urandom));
   endtask

   task automatic render(input logic [7:0] line, input logic [7:0] col);
      send_beat(OP_RENDER, ADDR_W'($urandom), 8'($urandom), line, col);
   endtask

   // tile number from the filled tile area
   function automatic logic [7:0] pick_tile();
      return FIRST_TILE | 8'($urandom_range(0, TILE_COUNT - 1));
   endfunction

   // low map entry at a map row and column
   function automatic logic [ADDR_W-1:0] map_entry(input int row, input int col);
      return MAP_LOW_OFF + ADDR_W'(row * MAP_STRIDE + col);
   endfunction

   // write that keeps every reachable map entry pointing at a filled tile
   task automatic random_store();
      case ($urandom_range(0, 2))
         0:       store_byte(map_entry($urandom_range(0, MAP_ROWS - 1),
                                       $urandom_range(0, MAP_COLS - 1)), pick_tile());
         1:       store_byte(TILE_AREA_OFF + ADDR_W'($urandom_range(0, TILE_AREA_BYTES - 1)),
                             8'($urandom));
         default: store_byte(ADDR_W'($urandom_range(0, MAP_LOW_OFF - 1)), 8'($urandom));
      endcase
   endtask

   // register beat; valid is left high for a following write
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_registers(input logic [7:0] sy, input logic [7:0] sx,
                                 input logic [7:0] wy, input logic [7:0] wx_raw,
                                 input logic [7:0] lcdc, input logic [7:0] palette);
      write_register(CSR_SCROLL_Y, sy);
      write_register(CSR_SCROLL_X, sx);
      write_register(CSR_WINDOW_Y, wy);
      write_register(CSR_WINDOW_X_RAW, wx_raw);
      write_register(CSR_LCD_CONTROL, lcdc);
      write_register(CSR_BG_PALETTE, palette);
      csr_valid <= 1'b0;
   endtask

   // stop offering, wait for every pixel, then for renders that give none
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly on-screen renders, some off-screen, a quarter writes
   task automatic random_items(input int count);
      logic [7:0] line, col;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            random_store();
         end else begin
            line = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(144, 255))
                                               : 8'($urandom_range(0, 143));
            col  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(160, 255))
                                               : 8'($urandom_range(0, 159));
            render(line, col);
         end
      end
   endtask

   // result side: random stall per beat, or a long hold-off when asked
   initial begin : result_sink
      int hold;
      while (reset) @(posedge clock);
      forever begin
         if (holdoff_request > 0) begin
            hold = holdoff_request;
            holdoff_request = 0;
         end else begin
            hold = idle_off ? 0 : $urandom_range(0, 7);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   // hard stop
   initial begin : watchdog
      #5ms;
      $display("tile_background_pixel_renderer_test: FAIL");
      $finish;
   end

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reachable low map entries and the tile rows they point at
      for (int r = 0; r < MAP_ROWS; r++)
         for (int c = 0; c < MAP_COLS; c++)
            store_byte(map_entry(r, c), pick_tile());
      for (int a = 0; a < TILE_AREA_BYTES; a++)
         store_byte(TILE_AREA_OFF + ADDR_W'(a), 8'($urandom));

      // screen corners and off-screen beats, background map high, unsigned tiles
      settle();
      load_registers(8'h00, 8'h00, 8'h00, 8'h07, BG_ON | BG_MAP_HI | TILES_UNSIGNED, 8'hE4);
      store_byte('0, 8'h00);
      store_byte('1, 8'hFF);
      // high map entries of the top-left and bottom-right pixels
      store_byte(13'h1C00, 8'h80);
      store_byte(13'h1E33, 8'h86);
      render(8'd0, 8'd0);
      render(8'd143, 8'd159);
      render(8'd144, 8'd10);
      render(8'd255, 8'd255);
      render(8'd5, 8'd160);
      // write-then-read on the map entry and the tile row of the top-left pixel
      store_byte(13'h1C00, 8'h81);
      render(8'd0, 8'd0);
      store_byte(13'h0810, 8'hAA);
      store_byte(13'h0811, 8'h55);
      render(8'd0, 8'd1);

      // background off, every other bit high, spare indexes written
      settle();
      write_register(CSR_SPARE_A, 8'hFF);
      write_register(CSR_SPARE_B, 8'hFF);
      load_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF & ~BG_ON, 8'hFF);
      render(8'd10, 8'd10);

      // window from line 20, window X at 80, signed tiles
      settle();
      load_registers(8'h44, 8'h33, 8'd20, 8'h57, BG_ON | WIN_ON | WIN_MAP_HI, 8'h1B);
      // high map entries left of the window edge and at the bottom-right pixel
      store_byte(13'h1C10, 8'h83);
      store_byte(13'h1DE9, 8'h85);
      render(8'd19, 8'd5);
      render(8'd20, 8'd79);
      render(8'd20, 8'd80);
      render(8'd143, 8'd159);

      // random phases, each under its own register setting
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         settle();
         case (k)
            0:       load_registers(8'h00, 8'h00, 8'h00, 8'h00,
                                    BG_ON | WIN_ON | TILES_UNSIGNED, 8'h00);
            1:       load_registers(8'(SCROLL_MAX), 8'(SCROLL_MAX), 8'hFF, 8'hFF,
                                    8'hFF & ~MAP_SELECTS, 8'hFF);
            default: load_registers(8'($urandom_range(0, SCROLL_MAX)),
                                    8'($urandom_range(0, SCROLL_MAX)),
                                    8'($urandom), 8'($urandom),
                                    (8'($urandom) | BG_ON) & ~MAP_SELECTS, 8'($urandom));
         endcase
         if (k == 3) begin
            // result side held off while items keep coming back to back
            holdoff_request = HOLDOFF_CYCLES;
            idle_off = 1'b1;
            random_items(PRESSURE_ITEMS);
            idle_off = 1'b0;
            random_items(PHASE_ITEMS - PRESSURE_ITEMS);
         end else if (k == 5) begin
            // no gaps on either side for a while
            idle_off = 1'b1;
            random_items(PHASE_ITEMS / 2);
            idle_off = 1'b0;
            random_items(PHASE_ITEMS / 2);
         end else begin
            random_items(PHASE_ITEMS);
         end
      end

      settle();
      if (mismatch_count == 0 && pending_pixels == 0)
         $display("tile_background_pixel_renderer_test: PASS");
      else
         $display("tile_background_pixel_renderer_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
